// ----- hdl/rlfe_pkg.sv -----
package rlfe_pkg;

	localparam int unsigned COUNT_W = 16;
	localparam logic [COUNT_W-1:0] MAX_PIXELS_RESET = 16'd64;

	localparam logic [2:0] LAST_COLOUR_STEP = 3'd5;
	localparam logic [2:0] LATCH_STEP = 3'd6;

	localparam logic [11:0] SYMBOL_ONES = 12'h924;
	localparam logic [11:0] LATCH_FRAME = 12'h000;

	typedef struct packed {
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
		logic       send_colour;
		logic       send_latch;
	} pixel_job_t;

	typedef struct packed {
		logic       valid;
		pixel_job_t job;
	} job_head_t;

	function automatic logic [11:0] encode_nibble(input logic [3:0] nib);
		logic [11:0] f;
		f = SYMBOL_ONES;
		f[10] = nib[3];
		f[7] = nib[2];
		f[4] = nib[1];
		f[1] = nib[0];
		return f;
	endfunction

endpackage

// ----- hdl/rlfe_front.sv -----
module rlfe_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [15:0]             cfg_wdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [23:0]             s_tdata,
	input  logic                    s_tlast,
	input  logic                    push_ready,
	output logic                    push_valid,
	output rlfe_pkg::pixel_job_t    push_job
);

	logic [rlfe_pkg::COUNT_W-1:0] max_pixels_q;
	logic [rlfe_pkg::COUNT_W-1:0] pixel_count_q;
	logic [rlfe_pkg::COUNT_W-1:0] next_count;
	logic                         accept;
	logic                         fits;
	logic                         latch;

	assign s_tready = push_ready;
	assign accept = s_tvalid & s_tready;
	assign fits = pixel_count_q < max_pixels_q;
	assign next_count = fits ? pixel_count_q + 16'd1 : pixel_count_q;
	assign latch = s_tlast & (next_count != '0);

	assign push_valid = accept & (fits | latch);
	assign push_job.red = s_tdata[7:0];
	assign push_job.green = s_tdata[15:8];
	assign push_job.blue = s_tdata[23:16];
	assign push_job.send_colour = fits;
	assign push_job.send_latch = latch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pixels_q <= rlfe_pkg::MAX_PIXELS_RESET;
			pixel_count_q <= '0;
		end else begin
			if (cfg_wen) begin
				max_pixels_q <= cfg_wdata;
			end
			if (accept) begin
				pixel_count_q <= latch ? '0 : next_count;
			end
		end
	end

endmodule

// ----- hdl/rlfe_queue.sv -----
module rlfe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  rlfe_pkg::pixel_job_t push_job,
	output rlfe_pkg::job_head_t  head,
	input  logic                 pop
);

	rlfe_pkg::pixel_job_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = fill_q != 2'd2;
	assign do_push = push_valid & push_ready;
	assign do_pop = pop & (fill_q != 2'd0);
	assign head.valid = fill_q != 2'd0;
	assign head.job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- hdl/rlfe_back.sv -----
module rlfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rlfe_pkg::job_head_t head,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);

	logic [2:0]  step_q;
	logic [2:0]  idx;
	logic        m_tvalid_q;
	logic [11:0] frame_q;
	logic        latch_q;
	logic        load;
	logic        final_frame;
	logic        is_latch;
	logic [3:0]  nib;

	assign idx = head.job.send_colour ? step_q : rlfe_pkg::LATCH_STEP;
	assign is_latch = idx == rlfe_pkg::LATCH_STEP;
	assign final_frame = is_latch
		| ((idx == rlfe_pkg::LAST_COLOUR_STEP) & ~head.job.send_latch);
	assign load = head.valid & (~m_tvalid_q | m_tready);
	assign pop = load & final_frame;

	always_comb begin
		unique case (idx)
			3'd0: nib = head.job.green[7:4];
			3'd1: nib = head.job.green[3:0];
			3'd2: nib = head.job.red[7:4];
			3'd3: nib = head.job.red[3:0];
			3'd4: nib = head.job.blue[7:4];
			3'd5: nib = head.job.blue[3:0];
			default: nib = 4'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= is_latch ? rlfe_pkg::LATCH_FRAME : rlfe_pkg::encode_nibble(nib);
			latch_q <= is_latch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				step_q <= final_frame ? 3'd0 : step_q + 3'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'd0, frame_q};
	assign m_tuser = latch_q;
	assign m_tlast = latch_q;

endmodule

// ----- hdl/rgb_led_frame_encoder_top.sv -----
// RGB LED frame encoder. Pixels enter on the slave stream and leave as serial
// frames on the master stream. Each pixel yields six 12-bit frames, green high
// nibble first and blue low nibble last, each colour bit sent as the symbol
// 1, b, 0. Pixels beyond the strip length held in the configuration register
// are dropped. A pixel marked by tlast ends the transfer: if any pixel of it
// was sent, an all-zero latch frame follows with tuser and tlast high.
// The first frame of a pixel passes through a queue slot and then the frame
// output register before it is valid. That register sends one word per cycle
// while the queue holds a pixel and the receiver is ready, and sets the pace.
// A two-entry queue between the input side and the frame generator lets new
// pixels be taken while frames are still going out. When the receiver stalls,
// the current word holds, the queue fills, and then s_tready falls until room
// frees up. Reset clears the queue, the output and the pixel count, and sets
// the strip length to 64. The user writes the strip length through cfg_wen and
// cfg_wdata only while the block is idle; the block does not enforce this.
module rgb_led_frame_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic        s_tlast,   // last_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // frame [11:0], zero [15:12]
	output logic        m_tuser,   // reset_phase
	output logic        m_tlast    // last
);

	logic                 push_ready;
	logic                 push_valid;
	rlfe_pkg::pixel_job_t push_job;
	rlfe_pkg::job_head_t  head;
	logic                 pop;

	rlfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	rlfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.head       (head),
		.pop        (pop)
	);

	rlfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- tb/rgb_led_frame_encoder_top_tb.sv -----
module rgb_led_frame_encoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned IDLE_PCT = 38;
	localparam logic [11:0] MARK_BITS = 12'h924;
	localparam int N_ROWS = 21;
	localparam int N_PHASES = 8;

	typedef enum logic {ROW_PIXEL, ROW_STRIP} row_kind_t;

	typedef struct packed {
		logic [11:0] frame;
		logic        reset_phase;
		logic        last;
	} led_word_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] strip;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
		logic        known;
		logic [2:0]  n_colour;
		logic [11:0] colour;
		logic        latch;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red [7:0], green [15:8], blue [23:16]
	logic        s_tlast;   // last_pixel
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // frame [11:0], zero [15:12]
	logic        m_tuser;   // reset_phase
	logic        m_tlast;   // last

	logic [rlfe_pkg::COUNT_W-1:0] strip_len;
	logic [rlfe_pkg::COUNT_W-1:0] sent_count;
	led_word_t frames_due [$];
	led_word_t head_word;
	int unsigned errors = 0;
	int unsigned stall_cycles = 0;
	int unsigned rx_holds_asked = 0;
	int unsigned rx_holds_done = 0;
	bit no_idle = 1'b0;

	// Known rows assume the strip length and pixel count that the rows above leave behind.
	stim_row_t dir_rows [N_ROWS] = '{
		'{ROW_PIXEL, 16'd0,     8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd6, 12'h924, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 3'd6, 12'hDB6, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h12, 8'h34, 8'h56, 1'b1, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h80, 8'h01, 8'h7E, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd6, 12'hDB6, 1'b1},
		'{ROW_STRIP, 16'd1,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hA5, 8'h5A, 8'h3C, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 3'd0, 12'h000, 1'b1},
		'{ROW_PIXEL, 16'd0,     8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 3'd6, 12'h924, 1'b1},
		'{ROW_STRIP, 16'd0,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 3'd0, 12'h000, 1'b0},
		'{ROW_STRIP, 16'hFFFF,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hC3, 8'h3C, 8'h96, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h69, 8'hF0, 8'h0F, 1'b1, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_STRIP, 16'd2,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h11, 8'h22, 8'h33, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h44, 8'h55, 8'h66, 1'b0, 1'b0, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'h77, 8'h88, 8'h99, 1'b0, 1'b1, 3'd0, 12'h000, 1'b0},
		'{ROW_PIXEL, 16'd0,     8'hAA, 8'hBB, 8'hCC, 1'b1, 1'b1, 3'd0, 12'h000, 1'b1}
	};

	rgb_led_frame_encoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [11:0] symbol_frame(input logic [3:0] nib);
		logic [11:0] f;
		f = MARK_BITS;
		for (int i = 0; i < 4; i++) begin
			if (nib[i])
				f[3*i+1] = 1'b1;
		end
		return f;
	endfunction

	task automatic track_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic lst, input bit push_words);
		logic [23:0] grb;
		logic [7:0]  colour;
		grb = {g, r, b};
		if (sent_count < strip_len) begin
			if (push_words) begin
				for (int c = 0; c < 3; c++) begin
					colour = grb[23-8*c -: 8];
					frames_due.push_back({symbol_frame(colour[7:4]), 1'b0, 1'b0});
					frames_due.push_back({symbol_frame(colour[3:0]), 1'b0, 1'b0});
				end
			end
			sent_count = sent_count + 1'b1;
		end
		if (lst && sent_count != 0) begin
			if (push_words)
				frames_due.push_back({rlfe_pkg::LATCH_FRAME, 1'b1, 1'b1});
			sent_count = '0;
		end
	endtask

	task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic lst, input bit push_words);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		track_pixel(r, g, b, lst, push_words);
	endtask

	task automatic drain_frames();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
	endtask

	// A dropped pixel leaves no word behind, so the block gets extra cycles before a write.
	task automatic write_strip(input logic [15:0] value);
		drain_frames();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		strip_len = value;
	endtask

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_holds_done != rx_holds_asked) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
				rx_holds_done++;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %h tuser %b tlast %b",
					$realtime, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				head_word = frames_due.pop_front();
				if (m_tdata !== {4'h0, head_word.frame}) begin
					$display("%0t: frame mismatch, expected %h actual %h",
						$realtime, {4'h0, head_word.frame}, m_tdata);
					errors++;
				end
				if (m_tuser !== head_word.reset_phase) begin
					$display("%0t: reset_phase mismatch, expected %b actual %b",
						$realtime, head_word.reset_phase, m_tuser);
					errors++;
				end
				if (m_tlast !== head_word.last) begin
					$display("%0t: last mismatch, expected %b actual %b",
						$realtime, head_word.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $realtime, stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0] phase_strip [N_PHASES];
		int unsigned phase_budget [N_PHASES];
		int unsigned sent;
		int unsigned len;
		int unsigned max_len;
		bit broken;
		logic lst;

		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		strip_len = rlfe_pkg::MAX_PIXELS_RESET;
		sent_count = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_STRIP) begin
				write_strip(dir_rows[i].strip);
			end else begin
				offer_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
					dir_rows[i].last, !dir_rows[i].known);
				if (dir_rows[i].known) begin
					for (int k = 0; k < dir_rows[i].n_colour; k++)
						frames_due.push_back({dir_rows[i].colour, 1'b0, 1'b0});
					if (dir_rows[i].latch)
						frames_due.push_back({rlfe_pkg::LATCH_FRAME, 1'b1, 1'b1});
				end
			end
		end

		phase_strip = '{16'd3, 16'd1, 16'hFFFF, 16'd5, 16'd0, 16'd2, 16'd0, 16'd64};
		phase_strip[6] = 16'($urandom_range(8, 1));
		phase_budget = '{30, 20, 30, 30, 6, 25, 30, 30};

		for (int p = 0; p < N_PHASES; p++) begin
			write_strip(phase_strip[p]);
			if (p == 0)
				rx_holds_asked++;
			no_idle = (p == 3);
			max_len = (phase_strip[p] <= 8) ? phase_strip[p] + 3 : 8;
			sent = 0;
			while (sent < phase_budget[p]) begin
				len = $urandom_range(max_len, 1);
				broken = ($urandom_range(99) < 15);
				for (int k = 0; k < len && sent < phase_budget[p]; k++) begin
					if (p == 6 && sent == 12)
						drain_frames();
					lst = broken ? ($urandom_range(3) == 0) : (k == len - 1);
					offer_pixel(8'($urandom), 8'($urandom), 8'($urandom), lst, 1'b1);
					sent++;
				end
			end
		end
		no_idle = 1'b0;

		drain_frames();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- rgb_led_frame_encoder_top.f -----
hdl/rlfe_pkg.sv
hdl/rlfe_front.sv
hdl/rlfe_queue.sv
hdl/rlfe_back.sv
hdl/rgb_led_frame_encoder_top.sv
tb/rgb_led_frame_encoder_top_tb.sv
